// ----- src/whp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the WAV header parser.
// Used by whp_ctrl, whp_datapath and wav_header_parser_unit; no dependencies.
package whp_pkg;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_HEADER = 2'd1,
        KIND_ERROR  = 2'd2
    } kind_t;

    localparam logic [3:0] ERR_RIFF      = 4'd0;
    localparam logic [3:0] ERR_SIZE      = 4'd1;
    localparam logic [3:0] ERR_WAVE      = 4'd2;
    localparam logic [3:0] ERR_FMT       = 4'd3;
    localparam logic [3:0] ERR_FMT_SIZE  = 4'd4;
    localparam logic [3:0] ERR_NOT_PCM   = 4'd5;
    localparam logic [3:0] ERR_BYTE_RATE = 4'd6;
    localparam logic [3:0] ERR_ALIGN     = 4'd7;
    localparam logic [3:0] ERR_DATA_TAG  = 4'd8;
    localparam logic [3:0] ERR_DATA_SIZE = 4'd9;
    localparam logic [3:0] ERR_TRUNC     = 4'd10;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;
    localparam logic [31:0] HDR_REST = 32'd36;
    localparam logic [31:0] FMT_SIZE = 32'd16;
    localparam logic [15:0] FMT_PCM  = 16'd1;

    // Header byte positions at which a field completes
    localparam logic [5:0] POS_RIFF      = 6'd3;
    localparam logic [5:0] POS_FILE_SIZE = 6'd7;
    localparam logic [5:0] POS_WAVE      = 6'd11;
    localparam logic [5:0] POS_FMT       = 6'd15;
    localparam logic [5:0] POS_FMT_SIZE  = 6'd19;
    localparam logic [5:0] POS_FORMAT    = 6'd21;
    localparam logic [5:0] POS_CHANNELS  = 6'd23;
    localparam logic [5:0] POS_RATE      = 6'd27;
    localparam logic [5:0] POS_BYTE_RATE = 6'd31;
    localparam logic [5:0] POS_ALIGN     = 6'd33;
    localparam logic [5:0] POS_BITS      = 6'd35;
    localparam logic [5:0] POS_DATA_TAG  = 6'd39;
    localparam logic [5:0] POS_DATA_SIZE = 6'd43;

    typedef struct packed {
        logic       shift_en;
        logic [5:0] pos;
        logic       mul_en;
        logic       rem_load;
        logic       rem_dec;
        logic       out_load;
        kind_t      kind;
        logic [3:0] code;
        logic       last;
    } whp_cmd_t;

    typedef struct packed {
        logic       hdr_err;
        logic [3:0] hdr_code;
        logic       size_zero;
        logic       rem_one;
        logic       chk_err;
        logic [3:0] chk_code;
        logic       out_free;
    } whp_status_t;

endpackage

// ----- src/wav_header_parser_unit.sv -----
`timescale 1ns / 1ps
// Top level of the WAV RIFF/PCM header parser: controller plus datapath.
// Depends on whp_pkg, whp_ctrl and whp_datapath.
//
// Takes a WAV file one byte per transfer (s_tuser marks file byte 0, s_tlast the
// end of the stream) and checks the 44-byte header. A good header gives one
// header transfer (kind 1), then each payload byte comes out as a data transfer
// (kind 0) with m_tlast on the final one; any failure or early end gives one
// error transfer (kind 2, m_tlast set) and later bytes are dropped until the next
// file start. Bytes are taken back to back, except after header byte 35: with rate
// times channels already registered, ST_MUL forms the byte rate and block align
// products and ST_CHECK compares them before the next byte is taken. A byte is
// taken only while the result register is empty or is read in the same cycle, so
// a waiting result stalls the input.
module wav_header_parser_unit
    import whp_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,      // [7:0] in_byte
    input  logic [0:0]    s_tuser,      // [0] file_start
    input  logic          s_tlast,      // stream_end
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [111:0]  m_tdata,      // [3:0] error_code, [11:4] out_byte,
                                        // [43:12] sample_rate, [59:44] channel_count,
                                        // [75:60] bits_per_sample, [107:76] payload_size
    output logic [1:0]    m_tuser,      // [1:0] kind
    output logic          m_tlast       // last
);

    whp_cmd_t    cmd;
    whp_status_t st;

    whp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .st       (st),
        .cmd      (cmd)
    );

    whp_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .st       (st),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> st.out_free)
        else $error("result loaded over a pending transfer");

    a_mul_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mul_en |-> !s_tready ##1 !s_tready)
        else $error("input taken during rate check");

    a_error_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_ERROR) |-> m_tlast)
        else $error("error transfer without last");

    a_kind_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == KIND_DATA) || (m_tuser == KIND_HEADER)
                     || (m_tuser == KIND_ERROR))
        else $error("illegal result kind");

endmodule

// ----- src/whp_ctrl.sv -----
`timescale 1ns / 1ps
// Parser controller: file phase, header byte position and the check sequence.
// Depends on whp_pkg; drives whp_datapath through whp_cmd_t.
module whp_ctrl
    import whp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [0:0]  s_tuser,
    input  logic        s_tlast,
    input  whp_status_t st,
    output whp_cmd_t    cmd
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_DATA,
        PH_IDLE
    } phase_t;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_MUL,
        ST_CHECK
    } state_t;

    state_t     state_reg, state_next;
    phase_t     phase_reg, phase_next;
    logic [5:0] pos_reg, pos_next;
    logic       end_reg, end_next;

    phase_t     eff_phase;
    logic [5:0] eff_pos;
    logic       fire;

    assign s_tready  = (state_reg == ST_RUN) && st.out_free;
    assign fire      = s_tvalid && s_tready;
    assign eff_phase = s_tuser[0] ? PH_HEADER : phase_reg;
    assign eff_pos   = s_tuser[0] ? 6'd0 : pos_reg;

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        pos_next   = pos_reg;
        end_next   = end_reg;
        cmd        = '0;
        cmd.pos    = eff_pos;
        case (state_reg)
            ST_RUN: begin
                if (fire) begin
                    phase_next = eff_phase;
                    pos_next   = eff_pos;
                    case (eff_phase)
                        PH_HEADER: begin
                            cmd.shift_en = 1'b1;
                            pos_next     = eff_pos + 6'd1;
                            if (st.hdr_err) begin
                                cmd.out_load = 1'b1;
                                cmd.kind     = KIND_ERROR;
                                cmd.code     = st.hdr_code;
                                cmd.last     = 1'b1;
                                phase_next   = PH_IDLE;
                            end else if (eff_pos == POS_BITS) begin
                                end_next   = s_tlast;
                                state_next = ST_MUL;
                            end else if (eff_pos == POS_DATA_SIZE) begin
                                cmd.out_load = 1'b1;
                                if (s_tlast && !st.size_zero) begin
                                    cmd.kind   = KIND_ERROR;
                                    cmd.code   = ERR_TRUNC;
                                    cmd.last   = 1'b1;
                                    phase_next = PH_IDLE;
                                end else begin
                                    cmd.kind     = KIND_HEADER;
                                    cmd.last     = st.size_zero;
                                    cmd.rem_load = 1'b1;
                                    phase_next   = st.size_zero ? PH_IDLE : PH_DATA;
                                end
                            end else if (s_tlast) begin
                                cmd.out_load = 1'b1;
                                cmd.kind     = KIND_ERROR;
                                cmd.code     = ERR_TRUNC;
                                cmd.last     = 1'b1;
                                phase_next   = PH_IDLE;
                            end
                        end
                        PH_DATA: begin
                            cmd.out_load = 1'b1;
                            if (s_tlast && !st.rem_one) begin
                                cmd.kind   = KIND_ERROR;
                                cmd.code   = ERR_TRUNC;
                                cmd.last   = 1'b1;
                                phase_next = PH_IDLE;
                            end else begin
                                cmd.kind    = KIND_DATA;
                                cmd.last    = st.rem_one;
                                cmd.rem_dec = 1'b1;
                                if (st.rem_one) begin
                                    phase_next = PH_IDLE;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_MUL: begin
                cmd.mul_en = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (st.out_free) begin
                    state_next = ST_RUN;
                    if (st.chk_err || end_reg) begin
                        cmd.out_load = 1'b1;
                        cmd.kind     = KIND_ERROR;
                        cmd.code     = st.chk_err ? st.chk_code : ERR_TRUNC;
                        cmd.last     = 1'b1;
                        phase_next   = PH_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_RUN;
            phase_reg <= PH_HEADER;
            pos_reg   <= 6'd0;
            end_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            end_reg   <= end_next;
        end
    end

endmodule

// ----- src/whp_datapath.sv -----
`timescale 1ns / 1ps
// Parser datapath: byte shifter, header fields, tag/size checks, rate multiplier,
// payload counter and the result register. Depends on whp_pkg.
module whp_datapath
    import whp_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [7:0]    s_tdata,      // [7:0] in_byte
    input  whp_cmd_t      cmd,
    output whp_status_t   st,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [111:0]  m_tdata,      // error_code, out_byte, sample_rate,
                                        // channel_count, bits_per_sample, payload_size
    output logic [1:0]    m_tuser,      // [1:0] kind
    output logic          m_tlast
);

    logic [31:0] shift_reg;
    logic [31:0] shift_next;
    logic [15:0] half_next;
    logic [31:0] file_size_reg;
    logic [15:0] channels_reg;
    logic [31:0] rate_reg;
    logic [31:0] byte_rate_reg;
    logic [15:0] align_reg;
    logic [15:0] bits_reg;
    logic [31:0] rem_reg;
    logic [31:0] rc_reg;
    logic [31:0] prod_reg;
    logic [31:0] cb_reg;
    logic [47:0] rc_full;
    logic [47:0] prod_full;
    logic [31:0] cb_full;

    logic        out_valid_reg;
    kind_t       kind_reg;
    logic [3:0]  code_reg;
    logic [7:0]  byte_reg;
    logic [31:0] rate_out_reg;
    logic [15:0] ch_out_reg;
    logic [15:0] bits_out_reg;
    logic [31:0] size_out_reg;
    logic        last_reg;

    assign shift_next = {s_tdata, shift_reg[31:8]};
    assign half_next  = shift_next[31:16];

    assign rc_full   = {16'b0, rate_reg} * {32'b0, channels_reg};
    assign prod_full = {16'b0, rc_reg} * {32'b0, bits_reg};
    assign cb_full   = {16'b0, channels_reg} * {16'b0, bits_reg};

    always_comb begin
        st.hdr_err  = 1'b0;
        st.hdr_code = ERR_RIFF;
        case (cmd.pos)
            POS_RIFF: begin
                st.hdr_err  = (shift_next != TAG_RIFF);
                st.hdr_code = ERR_RIFF;
            end
            POS_FILE_SIZE: begin
                st.hdr_err  = (shift_next < HDR_REST);
                st.hdr_code = ERR_SIZE;
            end
            POS_WAVE: begin
                st.hdr_err  = (shift_next != TAG_WAVE);
                st.hdr_code = ERR_WAVE;
            end
            POS_FMT: begin
                st.hdr_err  = (shift_next != TAG_FMT);
                st.hdr_code = ERR_FMT;
            end
            POS_FMT_SIZE: begin
                st.hdr_err  = (shift_next != FMT_SIZE);
                st.hdr_code = ERR_FMT_SIZE;
            end
            POS_FORMAT: begin
                st.hdr_err  = (half_next != FMT_PCM);
                st.hdr_code = ERR_NOT_PCM;
            end
            POS_DATA_TAG: begin
                st.hdr_err  = (shift_next != TAG_DATA);
                st.hdr_code = ERR_DATA_TAG;
            end
            POS_DATA_SIZE: begin
                st.hdr_err  = (shift_next != (file_size_reg - HDR_REST));
                st.hdr_code = ERR_DATA_SIZE;
            end
            default: begin
            end
        endcase
        st.size_zero = (shift_next == 32'd0);
        st.rem_one   = (rem_reg == 32'd1);
        if ({3'b0, prod_reg[31:3]} != byte_rate_reg) begin
            st.chk_err  = 1'b1;
            st.chk_code = ERR_BYTE_RATE;
        end else begin
            st.chk_err  = ({3'b0, cb_reg[31:3]} != {16'b0, align_reg});
            st.chk_code = ERR_ALIGN;
        end
        st.out_free = !out_valid_reg || m_tready;
    end

    always_ff @(posedge aclk) begin
        rc_reg <= rc_full[31:0];
        if (cmd.shift_en) begin
            shift_reg <= shift_next;
            case (cmd.pos)
                POS_FILE_SIZE: file_size_reg <= shift_next;
                POS_CHANNELS:  channels_reg  <= half_next;
                POS_RATE:      rate_reg      <= shift_next;
                POS_BYTE_RATE: byte_rate_reg <= shift_next;
                POS_ALIGN:     align_reg     <= half_next;
                POS_BITS:      bits_reg      <= half_next;
                default: begin
                end
            endcase
        end
        if (cmd.mul_en) begin
            prod_reg <= prod_full[31:0];
            cb_reg   <= cb_full;
        end
        if (cmd.rem_load) begin
            rem_reg <= shift_next;
        end else if (cmd.rem_dec) begin
            rem_reg <= rem_reg - 32'd1;
        end
        if (cmd.out_load) begin
            kind_reg     <= cmd.kind;
            code_reg     <= cmd.code;
            last_reg     <= cmd.last;
            byte_reg     <= (cmd.kind == KIND_DATA) ? s_tdata : 8'd0;
            rate_out_reg <= (cmd.kind == KIND_HEADER) ? rate_reg : 32'd0;
            ch_out_reg   <= (cmd.kind == KIND_HEADER) ? channels_reg : 16'd0;
            bits_out_reg <= (cmd.kind == KIND_HEADER) ? bits_reg : 16'd0;
            size_out_reg <= (cmd.kind == KIND_HEADER) ? shift_next : 32'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {4'b0, size_out_reg, bits_out_reg, ch_out_reg,
                       rate_out_reg, byte_reg, code_reg};

endmodule
